FILE: src/kdc_pkg.sv
package kdc_pkg;

  // Field widths.
  localparam int unsigned NIBBLE_W = 4;
  localparam int unsigned KEY_W    = 4;
  localparam int unsigned SEG_W    = 8;

  typedef logic [KEY_W-1:0] key_t;
  typedef logic [SEG_W-1:0] seg_t;

  // Key codes: 0 to 9 are the digits themselves.
  localparam key_t KEY_ADD  = 4'd10;
  localparam key_t KEY_SUB  = 4'd11;
  localparam key_t KEY_NONE = 4'd15;
  localparam key_t KEY_MAX_DIGIT = 4'd9;

  // Segment patterns that are not digits.
  localparam seg_t SEG_BLANK = 8'h00;
  localparam seg_t SEG_MINUS = 8'h40;

  // Key legends of the three keypad columns, indexed by row bit.
  localparam key_t LEFT_KEYS   [NIBBLE_W] = '{4'd1, 4'd4, 4'd7, KEY_ADD};
  localparam key_t MIDDLE_KEYS [NIBBLE_W] = '{4'd2, 4'd5, 4'd8, 4'd0};
  localparam key_t RIGHT_KEYS  [NIBBLE_W] = '{4'd3, 4'd6, 4'd9, KEY_SUB};

  // Display update produced by the entry sequencer for one poll.
  typedef struct packed {
    logic changed;
    seg_t seg_first;
    seg_t seg_second;
  } disp_upd_t;

  // Seven-segment pattern of one decimal digit.
  function automatic seg_t digit_seg(input key_t digit);
    seg_t seg;
    begin
      case (digit)
        4'd0:    seg = 8'h3F;
        4'd1:    seg = 8'h06;
        4'd2:    seg = 8'h5B;
        4'd3:    seg = 8'h4F;
        4'd4:    seg = 8'h66;
        4'd5:    seg = 8'h6D;
        4'd6:    seg = 8'h7D;
        4'd7:    seg = 8'h07;
        4'd8:    seg = 8'h7F;
        4'd9:    seg = 8'h6F;
        default: seg = SEG_BLANK;
      endcase
      return seg;
    end
  endfunction

endpackage

FILE: src/kdc_if.sv
// Keypad poll channel: three column nibbles per request.
interface kdc_in_if;
  logic                          valid;
  logic                          ready;
  logic [kdc_pkg::NIBBLE_W-1:0]  left_column_keys;
  logic [kdc_pkg::NIBBLE_W-1:0]  middle_column_keys;
  logic [kdc_pkg::NIBBLE_W-1:0]  right_column_keys;

  modport source (output valid, left_column_keys, middle_column_keys, right_column_keys,
                  input ready);
  modport sink   (input valid, left_column_keys, middle_column_keys, right_column_keys,
                  output ready);
endinterface

// Display channel: change flag and four segment bytes per request.
interface kdc_out_if;
  logic                 valid;
  logic                 ready;
  logic                 display_changed;
  kdc_pkg::seg_t        segments_first;
  kdc_pkg::seg_t        segments_second;
  kdc_pkg::seg_t        segments_third;
  kdc_pkg::seg_t        segments_fourth;

  modport source (output valid, display_changed, segments_first, segments_second,
                  segments_third, segments_fourth, input ready);
  modport sink   (input valid, display_changed, segments_first, segments_second,
                  segments_third, segments_fourth, output ready);
endinterface

FILE: src/keypad_digit_calculator.sv
// Keypad digit calculator. Each input request is one keypad poll and gives exactly
// one output request with the change flag and the four segment bytes of the display.
// A poll is captured in an input register, decoded and run through the entry
// sequencer once the output register is free, and lands in the output register;
// one poll is accepted every cycle while the output side keeps taking results.
// A stalled output holds its result; the input register then fills and ready drops
// until the output drains. The third and fourth display positions are
// always blank.
module keypad_digit_calculator (
  input  logic      clk,
  input  logic      rst_n,
  kdc_in_if.sink    in_chan,
  kdc_out_if.source out_chan
);

  logic                         s1_valid_r, s1_valid_nxt;
  logic [kdc_pkg::NIBBLE_W-1:0] s1_left_r, s1_middle_r, s1_right_r;
  logic                         out_valid_r, out_valid_nxt;
  logic                         changed_r, changed_nxt;
  kdc_pkg::seg_t                first_r, first_nxt;
  kdc_pkg::seg_t                second_r, second_nxt;

  logic               s1_adv;
  logic               in_take;
  logic               step_en;
  kdc_pkg::key_t      key;
  kdc_pkg::disp_upd_t upd;

  // Handshake: the poll stage moves on whenever the output register is free.
  assign s1_adv       = !out_valid_r || out_chan.ready;
  assign in_chan.ready = !s1_valid_r || s1_adv;
  assign in_take      = in_chan.valid && in_chan.ready;
  assign step_en      = s1_valid_r && s1_adv;

  assign s1_valid_nxt  = in_take || (s1_valid_r && !s1_adv);
  assign out_valid_nxt = s1_adv ? s1_valid_r : out_valid_r;

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_left_r   <= in_chan.left_column_keys;
      s1_middle_r <= in_chan.middle_column_keys;
      s1_right_r  <= in_chan.right_column_keys;
    end
  end

  kdc_key_decode u_decode (
    .left_keys   (s1_left_r),
    .middle_keys (s1_middle_r),
    .right_keys  (s1_right_r),
    .key         (key)
  );

  kdc_entry_seq u_seq (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (step_en),
    .key     (key),
    .upd     (upd)
  );

  // Output register; its segment bytes are also the held display contents.
  always_comb begin
    changed_nxt = changed_r;
    first_nxt   = first_r;
    second_nxt  = second_r;
    if (step_en) begin
      changed_nxt = upd.changed;
      if (upd.changed) begin
        first_nxt  = upd.seg_first;
        second_nxt = upd.seg_second;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      changed_r   <= 1'b0;
      first_r     <= kdc_pkg::SEG_BLANK;
      second_r    <= kdc_pkg::SEG_BLANK;
    end else begin
      out_valid_r <= out_valid_nxt;
      changed_r   <= changed_nxt;
      first_r     <= first_nxt;
      second_r    <= second_nxt;
    end
  end

  assign out_chan.valid           = out_valid_r;
  assign out_chan.display_changed = changed_r;
  assign out_chan.segments_first  = first_r;
  assign out_chan.segments_second = second_r;
  assign out_chan.segments_third  = kdc_pkg::SEG_BLANK;
  assign out_chan.segments_fourth = kdc_pkg::SEG_BLANK;

endmodule

FILE: src/kdc_key_decode.sv
module kdc_key_decode (
  input  logic [kdc_pkg::NIBBLE_W-1:0] left_keys,
  input  logic [kdc_pkg::NIBBLE_W-1:0] middle_keys,
  input  logic [kdc_pkg::NIBBLE_W-1:0] right_keys,
  output kdc_pkg::key_t                key
);

  // Priority decode: scan from lowest to highest priority so the last hit wins.
  // Left column beats middle beats right; within a column the lower bit wins.
  always_comb begin
    key = kdc_pkg::KEY_NONE;
    for (int i = kdc_pkg::NIBBLE_W - 1; i >= 0; i--) begin
      if (right_keys[i]) begin
        key = kdc_pkg::RIGHT_KEYS[i];
      end
    end
    for (int i = kdc_pkg::NIBBLE_W - 1; i >= 0; i--) begin
      if (middle_keys[i]) begin
        key = kdc_pkg::MIDDLE_KEYS[i];
      end
    end
    for (int i = kdc_pkg::NIBBLE_W - 1; i >= 0; i--) begin
      if (left_keys[i]) begin
        key = kdc_pkg::LEFT_KEYS[i];
      end
    end
  end

endmodule

FILE: src/kdc_entry_seq.sv
module kdc_entry_seq (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                step_en,
  input  kdc_pkg::key_t       key,
  output kdc_pkg::disp_upd_t  upd
);

  typedef enum logic [1:0] {
    STEP_FIRST  = 2'd0,
    STEP_OPER   = 2'd1,
    STEP_SECOND = 2'd2
  } step_t;

  step_t          step_r, step_nxt;
  kdc_pkg::key_t  operand_r, operand_nxt;
  logic           sub_r, sub_nxt;
  kdc_pkg::key_t  prev_key_r;

  logic           press;
  logic           is_digit;
  logic           is_oper;
  logic           neg;
  kdc_pkg::key_t  mag;
  logic [kdc_pkg::KEY_W:0] sum;
  kdc_pkg::disp_upd_t single_upd;
  kdc_pkg::disp_upd_t outcome_upd;

  // Press edge: a real key that differs from the previous poll.
  assign press    = (key != kdc_pkg::KEY_NONE) && (key != prev_key_r);
  assign is_digit = (key <= kdc_pkg::KEY_MAX_DIGIT);
  assign is_oper  = (key == kdc_pkg::KEY_ADD) || (key == kdc_pkg::KEY_SUB);

  // Single digit shown alone in the first position.
  always_comb begin
    single_upd.changed    = 1'b1;
    single_upd.seg_first  = kdc_pkg::digit_seg(key);
    single_upd.seg_second = kdc_pkg::SEG_BLANK;
  end

  // Arithmetic outcome of first operand and the key as second operand.
  assign neg = (operand_r < key);
  assign mag = neg ? (key - operand_r) : (operand_r - key);
  assign sum = {1'b0, operand_r} + {1'b0, key};

  always_comb begin
    outcome_upd.changed    = 1'b1;
    outcome_upd.seg_second = kdc_pkg::SEG_BLANK;
    if (sub_r) begin
      if (neg) begin
        outcome_upd.seg_first  = kdc_pkg::SEG_MINUS;
        outcome_upd.seg_second = kdc_pkg::digit_seg(mag);
      end else begin
        outcome_upd.seg_first  = kdc_pkg::digit_seg(mag);
      end
    end else if (sum > {1'b0, kdc_pkg::KEY_MAX_DIGIT}) begin
      // Sum of two digits stays below 20, so the tens digit is one.
      outcome_upd.seg_first  = kdc_pkg::digit_seg(kdc_pkg::key_t'(1));
      outcome_upd.seg_second = kdc_pkg::digit_seg(kdc_pkg::key_t'(sum - 5'd10));
    end else begin
      outcome_upd.seg_first  = kdc_pkg::digit_seg(sum[kdc_pkg::KEY_W-1:0]);
    end
  end

  // Entry sequence: first operand, operator, second operand.
  always_comb begin
    step_nxt    = step_r;
    operand_nxt = operand_r;
    sub_nxt     = sub_r;
    upd         = '0;
    if (press) begin
      unique case (step_r)
        STEP_SECOND: begin
          if (is_digit) begin
            upd      = outcome_upd;
            step_nxt = STEP_FIRST;
          end
        end
        STEP_OPER: begin
          if (is_oper) begin
            sub_nxt     = (key == kdc_pkg::KEY_SUB);
            upd.changed = 1'b1;
            step_nxt    = STEP_SECOND;
          end else if (is_digit) begin
            operand_nxt = key;
            upd         = single_upd;
          end
        end
        default: begin
          // The unused step code acts as the first step.
          if (is_digit) begin
            operand_nxt = key;
            upd         = single_upd;
            step_nxt    = STEP_OPER;
          end
        end
      endcase
    end
  end

  // Sequencer state, advanced once per processed poll.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r     <= STEP_FIRST;
      operand_r  <= '0;
      sub_r      <= 1'b0;
      prev_key_r <= kdc_pkg::KEY_NONE;
    end else if (step_en) begin
      step_r     <= step_nxt;
      operand_r  <= operand_nxt;
      sub_r      <= sub_nxt;
      prev_key_r <= key;
    end
  end

endmodule

FILE: src/kdc_checker.sv
module kdc_checker (
  input logic          clk,
  input logic          rst_n,
  input logic          in_ready,
  input logic          out_valid,
  input logic          out_ready,
  input logic          display_changed,
  input kdc_pkg::seg_t seg_first,
  input kdc_pkg::seg_t seg_second,
  input kdc_pkg::seg_t seg_third,
  input kdc_pkg::seg_t seg_fourth
);

  // No result is offered in the cycle after reset.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result offered right after reset");

  // A stalled result holds its contents.
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(display_changed)
      && $stable(seg_first) && $stable(seg_second))
    else $error("stalled result changed");

  // With the output side empty the block must take a new request.
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output");

  // A minus sign always comes with a magnitude digit in the second position.
  a_minus_magnitude: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && seg_first == kdc_pkg::SEG_MINUS |-> seg_second != kdc_pkg::SEG_BLANK)
    else $error("minus shown without magnitude");

  // The third and fourth display positions are always blank.
  a_blank_tail: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> seg_third == kdc_pkg::SEG_BLANK && seg_fourth == kdc_pkg::SEG_BLANK)
    else $error("unused display positions not blank");

endmodule

bind keypad_digit_calculator kdc_checker u_kdc_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_ready        (in_chan.ready),
  .out_valid       (out_chan.valid),
  .out_ready       (out_chan.ready),
  .display_changed (out_chan.display_changed),
  .seg_first       (out_chan.segments_first),
  .seg_second      (out_chan.segments_second),
  .seg_third       (out_chan.segments_third),
  .seg_fourth      (out_chan.segments_fourth)
);
